/* sv/tvns_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvns_pkg
// Shared types and constants for the two-voice note sequencer.
// ----------------------------------------------------------------------------
package tvns_pkg;

    localparam int NOTE_DEPTH = 256;
    localparam int ADDR_W     = 8;     // log2(NOTE_DEPTH)
    localparam int POS_W      = 9;     // holds 0..NOTE_DEPTH
    localparam int TICK_BITS  = 16;
    localparam int FREQ_W     = 16;
    localparam int DUR_W      = 16;
    localparam int LEN_W      = 9;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_PLAY  = 2'd2,
        ACT_STOP  = 2'd3
    } t_action;

    localparam logic [1:0] VOICE_MEL  = 2'd0;
    localparam logic [1:0] VOICE_HAR  = 2'd1;
    localparam logic [1:0] VOICE_BOTH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MEL_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HAR_LEN = 1'b1;

    // table entry: duration in the upper half, frequency in the lower half
    typedef struct packed {
        logic [DUR_W-1:0]  dur;
        logic [FREQ_W-1:0] freq;
    } t_note;

    typedef struct packed {
        t_action           action;
        logic [1:0]        voice;
        logic [ADDR_W-1:0] note_index;
        logic [FREQ_W-1:0] note_freq;
        logic [DUR_W-1:0]  note_ticks;
    } t_in_item;

    typedef struct packed {
        logic [FREQ_W-1:0] melody_tone;
        logic [FREQ_W-1:0] harmony_tone;
        logic              melody_active;
        logic              harmony_active;
        logic [POS_W-1:0]  melody_position;
    } t_out_item;

    // per-voice command, decoded at the top level
    typedef struct packed {
        logic              tick;
        logic              play;
        logic              stop;
        logic              wr;
        logic [ADDR_W-1:0] wr_idx;
        t_note             wr_note;
        logic              len_we;
        logic [LEN_W-1:0]  len_val;
    } t_voice_cmd;

endpackage

/* sv/tvns_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvns_in_if
// Valid/ready channel carrying sequencer command items.
// ----------------------------------------------------------------------------
interface tvns_in_if;
    logic               valid;
    logic               ready;
    tvns_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

/* sv/tvns_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvns_out_if
// Valid/ready channel carrying sequencer status items.
// ----------------------------------------------------------------------------
interface tvns_out_if;
    logic                valid;
    logic                ready;
    tvns_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

/* sv/tvns_voice.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvns_voice
// One voice: note table, position, elapsed tick count and tone output.
// ----------------------------------------------------------------------------
module tvns_voice (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tvns_pkg::t_voice_cmd          i_cmd,
    output logic [tvns_pkg::FREQ_W-1:0]   o_tone,
    output logic                          o_active,
    output logic [tvns_pkg::POS_W-1:0]    o_pos
);

    tvns_pkg::t_note                  r_table [tvns_pkg::NOTE_DEPTH];
    tvns_pkg::t_note                  r_rd;      // entry at r_pos + 1
    tvns_pkg::t_note                  r_first, n_first;
    logic [tvns_pkg::LEN_W-1:0]       r_len, n_len;
    logic [tvns_pkg::POS_W-1:0]       r_pos, n_pos;
    logic [tvns_pkg::TICK_BITS-1:0]   r_elapsed, n_elapsed;
    logic                             r_on, n_on;
    logic [tvns_pkg::FREQ_W-1:0]      r_out, n_out;
    logic [tvns_pkg::DUR_W-1:0]       r_cur_dur, n_cur_dur;

    logic [tvns_pkg::LEN_W-1:0]       w_used;
    logic [tvns_pkg::TICK_BITS-1:0]   w_elapsed_inc;
    logic [tvns_pkg::POS_W-1:0]       w_pos_inc;
    logic [tvns_pkg::POS_W-1:0]       w_rd_sum;
    logic [tvns_pkg::ADDR_W-1:0]      w_rd_addr;

    always_comb begin
        w_used = (r_len > tvns_pkg::LEN_W'(tvns_pkg::NOTE_DEPTH))
               ? tvns_pkg::LEN_W'(tvns_pkg::NOTE_DEPTH) : r_len;
        w_elapsed_inc = (r_elapsed == '1) ? r_elapsed
                      : r_elapsed + tvns_pkg::TICK_BITS'(1);
        w_pos_inc = r_pos + tvns_pkg::POS_W'(1);

        n_first   = r_first;
        n_len     = r_len;
        n_pos     = r_pos;
        n_elapsed = r_elapsed;
        n_on      = r_on;
        n_out     = r_out;
        n_cur_dur = r_cur_dur;

        if (i_cmd.len_we) begin
            n_len     = i_cmd.len_val;
            n_pos     = '0;
            n_cur_dur = r_first.dur;
        end

        if (i_cmd.tick && r_on) begin
            n_elapsed = w_elapsed_inc;
            if (w_elapsed_inc >= r_cur_dur) begin
                n_pos = w_pos_inc;
                if (w_pos_inc >= w_used) begin
                    n_on  = 1'b0;
                    n_out = '0;
                end else begin
                    n_elapsed = '0;
                    n_out     = r_rd.freq;
                    n_cur_dur = r_rd.dur;
                end
            end
        end

        if (i_cmd.play && (w_used != '0)) begin
            n_on      = 1'b1;
            n_pos     = '0;
            n_elapsed = '0;
            n_out     = r_first.freq;
            n_cur_dur = r_first.dur;
        end

        if (i_cmd.stop) begin
            n_on  = 1'b0;
            n_out = '0;
        end

        if (i_cmd.wr) begin
            if ({1'b0, i_cmd.wr_idx} == r_pos) begin
                n_cur_dur = i_cmd.wr_note.dur;
            end
            if (i_cmd.wr_idx == '0) begin
                n_first = i_cmd.wr_note;
            end
        end

        // prefetch the entry after the position we are moving to
        w_rd_sum  = n_pos + tvns_pkg::POS_W'(1);
        w_rd_addr = w_rd_sum[tvns_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_pos     <= '0;
            r_elapsed <= '0;
            r_on      <= 1'b0;
            r_out     <= '0;
            r_cur_dur <= '0;
        end else begin
            r_len     <= n_len;
            r_pos     <= n_pos;
            r_elapsed <= n_elapsed;
            r_on      <= n_on;
            r_out     <= n_out;
            r_cur_dur <= n_cur_dur;
        end
    end

    // entry 0 copy for play and length writes; no reset, table is unwritten
    always_ff @(posedge i_clk) begin
        r_first <= n_first;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_table[i_cmd.wr_idx] <= i_cmd.wr_note;
        end
    end

    // registered read with write bypass
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && (i_cmd.wr_idx == w_rd_addr)) begin
            r_rd <= i_cmd.wr_note;
        end else begin
            r_rd <= r_table[w_rd_addr];
        end
    end

    assign o_tone   = r_out;
    assign o_active = r_on;
    assign o_pos    = r_pos;

endmodule

/* sv/two_voice_note_sequencer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_voice_note_sequencer_top
// Two-voice tone sequencer: melody and harmony note tables played on ticks.
// ----------------------------------------------------------------------------
// Channel    Dir  Kind              Content
// i_in       in   valid/ready       action, voice, note_index, note_freq, note_ticks
// o_out      out  valid/ready       tones, active flags, melody position
// i_cfg_*    in   write enable      melody_length (0), harmony_length (1)
//
// One item per cycle unless its status stalls; each yields status the next cycle.
// The next table entry of each voice is prefetched from the table's
// registered read port, so consecutive note advances need no bubble.
// Synchronous active-low reset clears control state; tables are not cleared.
// A stalled status item holds i_in.ready low until it is taken.
// ----------------------------------------------------------------------------
module two_voice_note_sequencer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tvns_in_if.sink                          i_in,
    tvns_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [tvns_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tvns_pkg::LEN_W-1:0]       i_cfg_data
);

    logic                           w_acc;
    logic                           r_out_valid, n_out_valid;
    tvns_pkg::t_voice_cmd           w_mel_cmd, w_har_cmd;
    logic                           w_sel_mel, w_sel_har;
    tvns_pkg::t_note                w_note;

    logic [tvns_pkg::FREQ_W-1:0]    w_mel_tone, w_har_tone;
    logic                           w_mel_active, w_har_active;
    logic [tvns_pkg::POS_W-1:0]     w_mel_pos, w_har_pos;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;

    always_comb begin
        w_sel_mel = (i_in.item.voice == tvns_pkg::VOICE_MEL)
                 || (i_in.item.voice == tvns_pkg::VOICE_BOTH);
        w_sel_har = (i_in.item.voice == tvns_pkg::VOICE_HAR)
                 || (i_in.item.voice == tvns_pkg::VOICE_BOTH);
        w_note.dur  = i_in.item.note_ticks;
        w_note.freq = i_in.item.note_freq;

        w_mel_cmd = '0;
        w_har_cmd = '0;
        case (i_in.item.action)
            tvns_pkg::ACT_TICK: begin
                w_mel_cmd.tick = w_acc;
                w_har_cmd.tick = w_acc;
            end
            tvns_pkg::ACT_WRITE: begin
                // "both" is not a table, so a write to it is dropped
                w_mel_cmd.wr = w_acc && (i_in.item.voice == tvns_pkg::VOICE_MEL);
                w_har_cmd.wr = w_acc && (i_in.item.voice == tvns_pkg::VOICE_HAR);
            end
            tvns_pkg::ACT_PLAY: begin
                w_mel_cmd.play = w_acc && w_sel_mel;
                w_har_cmd.play = w_acc && w_sel_har;
            end
            tvns_pkg::ACT_STOP: begin
                w_mel_cmd.stop = w_acc && w_sel_mel;
                w_har_cmd.stop = w_acc && w_sel_har;
            end
            default: begin
                w_mel_cmd.tick = 1'b0;
            end
        endcase

        w_mel_cmd.wr_idx  = i_in.item.note_index;
        w_har_cmd.wr_idx  = i_in.item.note_index;
        w_mel_cmd.wr_note = w_note;
        w_har_cmd.wr_note = w_note;

        w_mel_cmd.len_we  = i_cfg_we && (i_cfg_idx == tvns_pkg::REG_MEL_LEN);
        w_har_cmd.len_we  = i_cfg_we && (i_cfg_idx == tvns_pkg::REG_HAR_LEN);
        w_mel_cmd.len_val = i_cfg_data;
        w_har_cmd.len_val = i_cfg_data;
    end

    tvns_voice u_mel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_mel_cmd),
        .o_tone   (w_mel_tone),
        .o_active (w_mel_active),
        .o_pos    (w_mel_pos)
    );

    tvns_voice u_har (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_har_cmd),
        .o_tone   (w_har_tone),
        .o_active (w_har_active),
        .o_pos    (w_har_pos)
    );

    // voice state moves only on an accepted transaction or a length write, so
    // without a length write it serves as the status payload while the transaction waits
    always_comb begin
        if (w_acc) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out.valid                = r_out_valid;
    assign o_out.item.melody_tone     = w_mel_tone;
    assign o_out.item.harmony_tone    = w_har_tone;
    assign o_out.item.melody_active   = w_mel_active;
    assign o_out.item.harmony_active  = w_har_active;
    assign o_out.item.melody_position = w_mel_pos;

    a_acc_gives_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_out_valid)
        else $error("accepted transaction produced no status");

    a_mel_silent_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_mel_active |-> (w_mel_tone == '0))
        else $error("melody tone nonzero while stopped");

    a_har_silent_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_har_active |-> (w_har_tone == '0))
        else $error("harmony tone nonzero while stopped");

    a_mel_pos_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mel_active |-> (w_mel_pos < tvns_pkg::POS_W'(tvns_pkg::NOTE_DEPTH)))
        else $error("melody playing past end of table");

    a_stall_holds_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> $stable({w_mel_pos, w_har_pos}))
        else $error("voice position moved during stalled status");

endmodule

/* tb/tb_two_voice_note_sequencer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_voice_note_sequencer_top
// Self-checking bench for the two-voice note sequencer. A short directed
// sequence covers rests, extreme notes, ignored writes, restarts and the end
// of a table. It is followed by phases of random commands under changing
// table lengths. A scoreboard class tracks both voices and checks every
// status transaction.
// ----------------------------------------------------------------------------
module tb_two_voice_note_sequencer_top;

    localparam int          N_PHASES        = 16;
    localparam int          ITEMS_PER_PHASE = 72;
    localparam int          IDLE_LIMIT      = 1000;
    localparam logic [1:0]  VOICE_NONE      = 2'd3;

    class tone_scoreboard;
        tvns_pkg::t_note                  notes [2][tvns_pkg::NOTE_DEPTH];
        logic [tvns_pkg::LEN_W-1:0]       len [2];
        logic [tvns_pkg::POS_W-1:0]       pos [2];
        logic [tvns_pkg::TICK_BITS-1:0]   elapsed [2];
        bit                               on [2];
        logic [tvns_pkg::FREQ_W-1:0]      tone [2];
        tvns_pkg::t_out_item              expected_status [$];
        int                               errors;
        int                               n_cmds;
        int                               n_checked;
        int                               n_ends;

        function new();
            for (int v = 0; v < 2; v++) begin
                foreach (notes[v][i]) notes[v][i] = '0;
                len[v]     = '0;
                pos[v]     = '0;
                elapsed[v] = '0;
                on[v]      = 1'b0;
                tone[v]    = '0;
            end
            errors    = 0;
            n_cmds    = 0;
            n_checked = 0;
            n_ends    = 0;
        endfunction

        function int used_len(int v);
            return (len[v] < tvns_pkg::NOTE_DEPTH) ? int'(len[v]) : tvns_pkg::NOTE_DEPTH;
        endfunction

        function tvns_pkg::t_note entry(int v, logic [tvns_pkg::POS_W-1:0] p);
            return (p < tvns_pkg::NOTE_DEPTH) ? notes[v][p[tvns_pkg::ADDR_W-1:0]] : '0;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void set_length(int v, logic [tvns_pkg::LEN_W-1:0] val);
            len[v] = val;
            pos[v] = '0;
        endfunction

        function void start_voice(int v);
            if (used_len(v) == 0) return;
            on[v]      = 1'b1;
            pos[v]     = '0;
            elapsed[v] = '0;
            tone[v]    = entry(v, '0).freq;
        endfunction

        function void stop_voice(int v);
            on[v]   = 1'b0;
            tone[v] = '0;
        endfunction

        function void tick_voice(int v);
            logic [tvns_pkg::DUR_W-1:0] dur;
            if (!on[v]) return;
            if (elapsed[v] != {tvns_pkg::TICK_BITS{1'b1}}) elapsed[v]++;
            dur = entry(v, pos[v]).dur;
            if (elapsed[v] >= dur) begin
                pos[v] = pos[v] + 1'b1;
                if (pos[v] >= used_len(v)) begin
                    // ran off the end of the table: position stays one past the note that ended
                    stop_voice(v);
                    n_ends++;
                end else begin
                    elapsed[v] = '0;
                    tone[v]    = entry(v, pos[v]).freq;
                end
            end
        endfunction

        function void note_command(tvns_pkg::t_in_item c);
            tvns_pkg::t_out_item s;
            n_cmds++;
            case (c.action)
                tvns_pkg::ACT_TICK: begin
                    tick_voice(0);
                    tick_voice(1);
                end
                tvns_pkg::ACT_WRITE: begin
                    if (c.voice == tvns_pkg::VOICE_MEL || c.voice == tvns_pkg::VOICE_HAR)
                        notes[c.voice[0]][c.note_index] = {c.note_ticks, c.note_freq};
                end
                tvns_pkg::ACT_PLAY: begin
                    if (c.voice == tvns_pkg::VOICE_MEL || c.voice == tvns_pkg::VOICE_BOTH)
                        start_voice(0);
                    if (c.voice == tvns_pkg::VOICE_HAR || c.voice == tvns_pkg::VOICE_BOTH)
                        start_voice(1);
                end
                default: begin
                    if (c.voice == tvns_pkg::VOICE_MEL || c.voice == tvns_pkg::VOICE_BOTH)
                        stop_voice(0);
                    if (c.voice == tvns_pkg::VOICE_HAR || c.voice == tvns_pkg::VOICE_BOTH)
                        stop_voice(1);
                end
            endcase
            s.melody_tone     = tone[0];
            s.harmony_tone    = tone[1];
            s.melody_active   = on[0];
            s.harmony_active  = on[1];
            s.melody_position = pos[0];
            expected_status.push_back(s);
        endfunction

        function void compare_field(string fname, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, fname, want, got);
            end
        endfunction

        function void check_status(tvns_pkg::t_out_item got);
            tvns_pkg::t_out_item want;
            n_checked++;
            if (expected_status.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected status transaction, expected none, actual %h",
                         $time, got);
            end else begin
                want = expected_status.pop_front();
                compare_field("melody_tone", want.melody_tone, got.melody_tone);
                compare_field("harmony_tone", want.harmony_tone, got.harmony_tone);
                compare_field("melody_active", want.melody_active, got.melody_active);
                compare_field("harmony_active", want.harmony_active, got.harmony_active);
                compare_field("melody_position", want.melody_position,
                              got.melody_position);
            end
        endfunction
    endclass

    logic                             i_clk   = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             cfg_we;
    logic [tvns_pkg::CFG_IDX_W-1:0]   cfg_idx;
    logic [tvns_pkg::LEN_W-1:0]       cfg_data;
    bit                               no_idle = 1'b0;
    bit                               written [2][tvns_pkg::NOTE_DEPTH];
    int                               n_len_writes = 0;
    int                               idle_cycles  = 0;
    tone_scoreboard                   sb;

    tvns_in_if  in_if ();
    tvns_out_if out_if ();

    two_voice_note_sequencer_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("** two_voice_note_sequencer_top: FAILED **");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic tvns_pkg::t_in_item note_cmd(tvns_pkg::t_action a, logic [1:0] v,
                                                    logic [tvns_pkg::ADDR_W-1:0] idx,
                                                    logic [tvns_pkg::FREQ_W-1:0] f,
                                                    logic [tvns_pkg::DUR_W-1:0] t);
        tvns_pkg::t_in_item c;
        c.action     = a;
        c.voice      = v;
        c.note_index = idx;
        c.note_freq  = f;
        c.note_ticks = t;
        return c;
    endfunction

    // mostly ticks; writes land on low entries so notes change under a playing voice
    function automatic tvns_pkg::t_in_item random_command();
        tvns_pkg::t_in_item c;
        int                 r;
        int                 rv;
        r  = $urandom_range(0, 99);
        rv = $urandom_range(0, 99);
        c.note_index = tvns_pkg::ADDR_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 15)
                                                                      : $urandom_range(0, 255));
        c.note_freq  = tvns_pkg::FREQ_W'(($urandom_range(0, 9) == 0) ? 0
                                                                      : $urandom_range(0, 65535));
        c.note_ticks = tvns_pkg::DUR_W'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                                     : $urandom_range(0, 3));
        if (r < 55)      c.action = tvns_pkg::ACT_TICK;
        else if (r < 72) c.action = tvns_pkg::ACT_WRITE;
        else if (r < 92) c.action = tvns_pkg::ACT_PLAY;
        else             c.action = tvns_pkg::ACT_STOP;
        if (c.action == tvns_pkg::ACT_WRITE)
            c.voice = (rv < 45) ? tvns_pkg::VOICE_MEL : (rv < 90) ? tvns_pkg::VOICE_HAR
                    : ((rv < 95) ? tvns_pkg::VOICE_BOTH : VOICE_NONE);
        else
            c.voice = (rv < 30) ? tvns_pkg::VOICE_MEL : (rv < 60) ? tvns_pkg::VOICE_HAR
                    : ((rv < 92) ? tvns_pkg::VOICE_BOTH : VOICE_NONE);
        return c;
    endfunction

    function automatic logic [tvns_pkg::LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 16) return tvns_pkg::LEN_W'(tvns_pkg::NOTE_DEPTH);
        if (r < 20) return '1;
        if (r < 28) return tvns_pkg::LEN_W'($urandom_range(0, 511));
        return tvns_pkg::LEN_W'($urandom_range(1, 8));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_command(input tvns_pkg::t_in_item c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.item  <= c;
        in_if.valid <= 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_command(c);
        if (c.action == tvns_pkg::ACT_WRITE
            && (c.voice == tvns_pkg::VOICE_MEL || c.voice == tvns_pkg::VOICE_HAR))
            written[c.voice[0]][c.note_index] = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic program_lengths(input logic [tvns_pkg::LEN_W-1:0] mel,
                                   input logic [tvns_pkg::LEN_W-1:0] har);
        cfg_we   <= 1'b1;
        cfg_idx  <= tvns_pkg::REG_MEL_LEN;
        cfg_data <= mel;
        @(posedge i_clk);
        sb.set_length(0, mel);
        @(negedge i_clk);
        cfg_idx  <= tvns_pkg::REG_HAR_LEN;
        cfg_data <= har;
        @(posedge i_clk);
        sb.set_length(1, har);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        n_len_writes += 2;
    endtask

    // every entry below the length in use must hold a note before it can be played
    task automatic fill_tables();
        for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < sb.used_len(v); i++) begin
                if (!written[v][i])
                    send_command(note_cmd(tvns_pkg::ACT_WRITE,
                                          (v == 0) ? tvns_pkg::VOICE_MEL : tvns_pkg::VOICE_HAR,
                                          tvns_pkg::ADDR_W'(i),
                                          tvns_pkg::FREQ_W'($urandom_range(0, 65535)),
                                          tvns_pkg::DUR_W'($urandom_range(0, 3))));
            end
        end
    endtask

    initial begin
        int stall;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            sb.check_status(out_if.item);
            @(negedge i_clk);
        end
    end

    initial begin
        sb          = new();
        in_if.valid = 1'b0;
        in_if.item  = '0;
        cfg_we      = 1'b0;
        cfg_idx     = '0;
        cfg_data    = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // lengths still zero: nothing can start
        send_command(note_cmd(tvns_pkg::ACT_TICK, tvns_pkg::VOICE_BOTH, 8'h00, 16'h0000,
                              16'h0000));
        send_command(note_cmd(tvns_pkg::ACT_PLAY, tvns_pkg::VOICE_BOTH, 8'h00, 16'h0000,
                              16'h0000));
        send_command(note_cmd(tvns_pkg::ACT_STOP, tvns_pkg::VOICE_BOTH, 8'h00, 16'h0000,
                              16'h0000));
        send_command(note_cmd(tvns_pkg::ACT_WRITE, tvns_pkg::VOICE_MEL, 8'd0, 16'hFFFF, 16'd0));
        send_command(note_cmd(tvns_pkg::ACT_WRITE, tvns_pkg::VOICE_MEL, 8'd1, 16'h0000, 16'd2));
        send_command(note_cmd(tvns_pkg::ACT_WRITE, tvns_pkg::VOICE_MEL, 8'd2, 16'h1234, 16'd1));
        send_command(note_cmd(tvns_pkg::ACT_WRITE, tvns_pkg::VOICE_HAR, 8'd0, 16'h8001,
                              16'hFFFF));
        send_command(note_cmd(tvns_pkg::ACT_WRITE, tvns_pkg::VOICE_BOTH, 8'd3, 16'hAAAA,
                              16'h5555));
        send_command(note_cmd(tvns_pkg::ACT_WRITE, VOICE_NONE, 8'd4, 16'h5555, 16'hAAAA));
        send_command(note_cmd(tvns_pkg::ACT_WRITE, tvns_pkg::VOICE_MEL, 8'hFF, 16'h5A5A, 16'd0));
        settle();
        program_lengths(9'd3, 9'd1);

        // melody: zero-length note, rest, restart, then past the last entry
        send_command(note_cmd(tvns_pkg::ACT_PLAY, tvns_pkg::VOICE_BOTH, 8'h00, 16'h0000,
                              16'h0000));
        send_command(note_cmd(tvns_pkg::ACT_TICK, tvns_pkg::VOICE_MEL, 8'h00, 16'h0000,
                              16'h0000));
        send_command(note_cmd(tvns_pkg::ACT_TICK, tvns_pkg::VOICE_MEL, 8'h00, 16'h0000,
                              16'h0000));
        send_command(note_cmd(tvns_pkg::ACT_PLAY, tvns_pkg::VOICE_MEL, 8'h00, 16'h0000,
                              16'h0000));
        send_command(note_cmd(tvns_pkg::ACT_TICK, tvns_pkg::VOICE_MEL, 8'h00, 16'h0000,
                              16'h0000));
        send_command(note_cmd(tvns_pkg::ACT_PLAY, VOICE_NONE, 8'h00, 16'h0000, 16'h0000));
        send_command(note_cmd(tvns_pkg::ACT_STOP, VOICE_NONE, 8'h00, 16'h0000, 16'h0000));
        repeat (4) send_command(note_cmd(tvns_pkg::ACT_TICK, tvns_pkg::VOICE_MEL, 8'hFF,
                                         16'hFFFF, 16'hFFFF));
        send_command(note_cmd(tvns_pkg::ACT_STOP, tvns_pkg::VOICE_HAR, 8'h00, 16'h0000,
                              16'h0000));
        send_command(note_cmd(tvns_pkg::ACT_TICK, tvns_pkg::VOICE_BOTH, 8'h00, 16'h0000,
                              16'h0000));
        settle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            no_idle = (ph % 4 == 3);
            case (ph)
                5:       program_lengths(tvns_pkg::LEN_W'(tvns_pkg::NOTE_DEPTH), '1);
                6:       program_lengths('1, '0);
                default: program_lengths(pick_length(), pick_length());
            endcase
            fill_tables();
            repeat (ITEMS_PER_PHASE) send_command(random_command());
            settle();
        end

        $display("Sent %0d commands over %0d length settings; %0d status transactions checked.",
                 sb.n_cmds, n_len_writes, sb.n_checked);
        $display("Voices ran off the end of their table %0d times.", sb.n_ends);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** two_voice_note_sequencer_top: PASSED **");
        end else begin
            $display("** two_voice_note_sequencer_top: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/tvns_pkg.sv
sv/tvns_in_if.sv
sv/tvns_out_if.sv
sv/tvns_voice.sv
sv/two_voice_note_sequencer_top.sv
tb/tb_two_voice_note_sequencer_top.sv
